[design/shrs_pkg.sv]
// Shared types and constants for the streaming-aware RRIP replacement core.
// Depends on nothing; imported by the row evaluator and the top level.
`default_nettype none

package shrs_pkg;

  localparam int unsigned DEF_NUM_SETS    = 2048;
  localparam int unsigned DEF_NUM_WAYS    = 16;
  localparam int unsigned DEF_SIG_ENTRIES = 1024;

  localparam int unsigned BLK_W     = 32;
  localparam int unsigned PC_W      = 64;
  localparam int unsigned SIG_W     = 5;
  localparam int unsigned CTR_W     = 2;
  localparam int unsigned RRPV_W    = 2;
  localparam int unsigned MAX_WAY_W = 5;
  localparam int unsigned OUT_WAY_W = 4;

  localparam int unsigned SIG_SHIFT  = 5;
  localparam int unsigned IDX_SHIFT  = 10;
  localparam int unsigned EIDX_SHIFT = 2;

  localparam logic [SIG_W-1:0]  SIG_MASK   = 5'h1F;
  localparam logic [RRPV_W-1:0] RRPV_MAX   = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_NEAR  = 2'd0;
  localparam logic [CTR_W-1:0]  CTR_RESET  = 2'd1;
  localparam logic [CTR_W-1:0]  CTR_MAX    = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_THRESH = 2'd2;

  localparam logic REQ_VICTIM = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_DEC
  } shrs_state_e;

  typedef struct packed {
    logic [MAX_WAY_W-1:0] victim;
    logic [SIG_W-1:0]     old_sig;
    logic [CTR_W-1:0]     ctr_inc;
  } shrs_eval_t;

endpackage

`default_nettype wire

[design/shrs_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Standalone; no package dependency.
`default_nettype none

module shrs_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/shrs_row_eval.sv]
// Set-row evaluator: ageing and victim search, hit promotion, fill insertion
// and streaming detection on one read set row. Depends on shrs_pkg.
`default_nettype none

module shrs_row_eval #(
  parameter int unsigned NUM_WAYS = 16,
  parameter int unsigned WAY_W    = 4,
  parameter int unsigned ROW_W    = 145
) (
  input  logic [ROW_W-1:0]             row_i,
  input  logic                         req_type_i,
  input  logic [WAY_W-1:0]             way_i,
  input  logic                         hit_i,
  input  logic [shrs_pkg::SIG_W-1:0]   sig_i,
  input  logic [shrs_pkg::BLK_W-1:0]   blk_i,
  input  logic [shrs_pkg::CTR_W-1:0]   ctr_i,
  output logic [ROW_W-1:0]             row_o,
  output shrs_pkg::shrs_eval_t         eval_o
);

  import shrs_pkg::*;

  localparam int unsigned RR_BASE  = 0;
  localparam int unsigned SG_BASE  = NUM_WAYS * RRPV_W;
  localparam int unsigned ST_BIT   = NUM_WAYS * (RRPV_W + SIG_W);
  localparam int unsigned BLK_BASE = ST_BIT + 1;

  logic [RRPV_W-1:0] rr     [NUM_WAYS];
  logic [RRPV_W-1:0] aged   [NUM_WAYS];
  logic [RRPV_W-1:0] new_rr [NUM_WAYS];
  logic [SIG_W-1:0]  sg     [NUM_WAYS];
  logic [SIG_W-1:0]  new_sg [NUM_WAYS];
  logic [NUM_WAYS-1:0] hi_bits;
  logic [NUM_WAYS-1:0] lo_top;
  logic [RRPV_W-1:0] top;
  logic [RRPV_W-1:0] add;
  logic [RRPV_W-1:0] ins;
  logic [WAY_W-1:0]  first;
  logic [BLK_W-1:0]  prev;
  logic [BLK_W-1:0]  delta;
  logic              stream_old;
  logic              stream_new;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rr[w] = row_i[RR_BASE + w*RRPV_W +: RRPV_W];
      sg[w] = row_i[SG_BASE + w*SIG_W +: SIG_W];
    end
    stream_old = row_i[ST_BIT];
    prev       = row_i[BLK_BASE +: BLK_W];

    for (int w = 0; w < NUM_WAYS; w++) begin
      hi_bits[w] = rr[w][1];
    end
    top[1] = |hi_bits;
    for (int w = 0; w < NUM_WAYS; w++) begin
      lo_top[w] = rr[w][0] & (rr[w][1] == top[1]);
    end
    top[0] = |lo_top;
    add    = RRPV_MAX - top;

    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = rr[w] + add;
    end
    first = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged[w] == RRPV_MAX) begin
        first = WAY_W'(w);
      end
    end

    delta = blk_i - prev;
    if (prev != '0 && (delta == BLK_W'(1) || delta == '1)) begin
      stream_new = 1'b1;
    end else if (prev != '0 && delta != '0) begin
      stream_new = 1'b0;
    end else begin
      stream_new = stream_old;
    end

    if (stream_new) begin
      ins = RRPV_MAX;
    end else begin
      ins = (ctr_i >= CTR_THRESH) ? RRPV_NEAR : RRPV_MAX;
    end

    for (int w = 0; w < NUM_WAYS; w++) begin
      new_rr[w] = rr[w];
      new_sg[w] = sg[w];
    end
    row_o = row_i;
    if (req_type_i == REQ_VICTIM) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        new_rr[w] = aged[w];
      end
    end else begin
      new_rr[way_i] = hit_i ? RRPV_NEAR : ins;
      if (!hit_i) begin
        new_sg[way_i] = sig_i;
      end
      row_o[ST_BIT]              = stream_new;
      row_o[BLK_BASE +: BLK_W]   = blk_i;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_o[RR_BASE + w*RRPV_W +: RRPV_W] = new_rr[w];
      row_o[SG_BASE + w*SIG_W +: SIG_W]   = new_sg[w];
    end

    eval_o.victim  = MAX_WAY_W'(first);
    eval_o.old_sig = sg[way_i];
    eval_o.ctr_inc = (ctr_i == CTR_MAX) ? ctr_i : ctr_i + CTR_W'(1);
  end

endmodule

`default_nettype wire

[design/ship_rrip_streaming_replacement_core.sv]
// Channel  | Direction | Handshake          | Fields
// request  | in        | start / busy       | req_type, set_index, way, blk_addr, pc, hit
// victim   | out       | victim_valid_o     | victim_way
//
// Victim requests and update hits read the set row and reuse counter, then
// modify and write the row back; update misses add one more read-modify-write
// of the evicted signature's counter.
// After reset the core sweeps max(NUM_SETS, SIG_ENTRIES) addresses (2048 by
// default) to initialise both memories; busy stays high meanwhile.
// Results appear in the cycle after the writeback cycle; the receiver cannot stall.
// Depends on shrs_pkg, shrs_ram and shrs_row_eval.
`default_nettype none

module ship_rrip_streaming_replacement_core #(
  parameter int unsigned NUM_SETS    = shrs_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS    = shrs_pkg::DEF_NUM_WAYS,
  parameter int unsigned SIG_ENTRIES = shrs_pkg::DEF_SIG_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type_i,
  input  logic [10:0]                    set_index_i,
  input  logic [3:0]                     way_i,
  input  logic [shrs_pkg::BLK_W-1:0]     blk_addr_i,
  input  logic [shrs_pkg::PC_W-1:0]      pc_i,
  input  logic                           hit_i,
  output logic                           victim_valid_o,
  output logic [shrs_pkg::OUT_WAY_W-1:0] victim_way_o
);

  import shrs_pkg::*;

  localparam int unsigned AW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned CW     = $clog2(SIG_ENTRIES);
  localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
  localparam int unsigned ROW_W  = NUM_WAYS * (RRPV_W + SIG_W) + 1 + BLK_W;
  localparam int unsigned CLR_N  = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
  localparam logic [ROW_W-1:0] ROW_RST  = ROW_W'({NUM_WAYS{RRPV_MAX}});
  localparam logic [PC_W-1:0]  CTR_MASK = PC_W'(SIG_ENTRIES - 1);

  shrs_state_e state_q, state_d;
  logic [CLR_W-1:0] clr_q, clr_d;

  logic              req_q;
  logic [AW-1:0]     set_q;
  logic [WAY_W-1:0]  way_q;
  logic              hit_q;
  logic [BLK_W-1:0]  blk_q;
  logic [SIG_W-1:0]  sig_q;
  logic [CW-1:0]     gidx_q;
  logic [CW-1:0]     eidx_q;
  logic              victim_valid_q, victim_valid_d;
  logic [OUT_WAY_W-1:0] victim_way_q, victim_way_d;

  logic              accept;
  logic              req_ok;
  logic [AW-1:0]     set_addr;
  logic [SIG_W-1:0]  sig_c;
  logic [PC_W-1:0]   hash_c;
  logic [CW-1:0]     gidx_c;
  logic [CW-1:0]     eidx_c;
  logic [31:0]       eidx_full;

  logic              row_we;
  logic [AW-1:0]     row_waddr;
  logic [ROW_W-1:0]  row_wdata;
  logic [ROW_W-1:0]  row_rdata;
  logic [ROW_W-1:0]  row_next;
  logic              ctr_we;
  logic [CW-1:0]     ctr_waddr;
  logic [CW-1:0]     ctr_raddr;
  logic [CTR_W-1:0]  ctr_wdata;
  logic [CTR_W-1:0]  ctr_rdata;
  logic [CTR_W-1:0]  ctr_dec;
  shrs_eval_t        eval;

  assign set_addr = AW'(set_index_i);
  assign sig_c    = (pc_i[SIG_W-1:0] ^ pc_i[SIG_SHIFT +: SIG_W]) & SIG_MASK;
  assign hash_c   = (pc_i ^ (pc_i >> IDX_SHIFT) ^ (pc_i >> SIG_SHIFT)) & CTR_MASK;
  assign gidx_c   = hash_c[CW-1:0];
  assign eidx_full = (32'(eval.old_sig) ^ (32'(eval.old_sig) << EIDX_SHIFT))
                     & 32'(SIG_ENTRIES - 1);
  assign eidx_c   = eidx_full[CW-1:0];
  assign ctr_dec  = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - CTR_W'(1);

  assign req_ok = (32'(set_index_i) < NUM_SETS) &&
                  (req_type_i == REQ_VICTIM || 32'(way_i) < NUM_WAYS);
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  shrs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS),
    .ADDR_W(AW)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(row_waddr),
    .wdata_i(row_wdata),
    .raddr_i(set_addr),
    .rdata_o(row_rdata)
  );

  shrs_ram #(
    .WIDTH (CTR_W),
    .DEPTH (SIG_ENTRIES),
    .ADDR_W(CW)
  ) u_ctr_ram (
    .clk_i  (clk_i),
    .we_i   (ctr_we),
    .waddr_i(ctr_waddr),
    .wdata_i(ctr_wdata),
    .raddr_i(ctr_raddr),
    .rdata_o(ctr_rdata)
  );

  shrs_row_eval #(
    .NUM_WAYS(NUM_WAYS),
    .WAY_W   (WAY_W),
    .ROW_W   (ROW_W)
  ) u_row_eval (
    .row_i     (row_rdata),
    .req_type_i(req_q),
    .way_i     (way_q),
    .hit_i     (hit_q),
    .sig_i     (sig_q),
    .blk_i     (blk_q),
    .ctr_i     (ctr_rdata),
    .row_o     (row_next),
    .eval_o    (eval)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && req_ok) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = (req_q == REQ_UPDATE && !hit_q) ? S_DEC : S_IDLE;
      end
      S_DEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    row_we         = 1'b0;
    row_waddr      = set_q;
    row_wdata      = row_next;
    ctr_we         = 1'b0;
    ctr_waddr      = gidx_q;
    ctr_wdata      = eval.ctr_inc;
    ctr_raddr      = gidx_c;
    victim_valid_d = 1'b0;
    victim_way_d   = victim_way_q;
    unique case (state_q)
      S_CLEAR: begin
        row_we    = (32'(clr_q) < NUM_SETS);
        row_waddr = AW'(clr_q);
        row_wdata = ROW_RST;
        ctr_we    = (32'(clr_q) < SIG_ENTRIES);
        ctr_waddr = CW'(clr_q);
        ctr_wdata = CTR_RESET;
      end
      S_IDLE: begin
      end
      S_EVAL: begin
        row_we    = 1'b1;
        ctr_raddr = eidx_c;
        if (req_q == REQ_VICTIM) begin
          victim_valid_d = 1'b1;
          victim_way_d   = eval.victim[OUT_WAY_W-1:0];
        end else if (hit_q) begin
          ctr_we = 1'b1;
        end
      end
      S_DEC: begin
        ctr_we    = 1'b1;
        ctr_waddr = eidx_q;
        ctr_wdata = ctr_dec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      victim_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      victim_valid_q <= victim_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      set_q  <= set_addr;
      way_q  <= WAY_W'(way_i);
      hit_q  <= hit_i;
      blk_q  <= blk_addr_i;
      sig_q  <= sig_c;
      gidx_q <= gidx_c;
    end
    if (state_q == S_EVAL) begin
      eidx_q <= eidx_c;
    end
    victim_way_q <= victim_way_d;
  end

  assign victim_valid_o = victim_valid_q;
  assign victim_way_o   = victim_way_q;

  a_result_from_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_valid_q |-> $past(state_q == S_EVAL && req_q == REQ_VICTIM))
    else $error("victim result without a victim evaluation");

  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !victim_valid_q)
    else $error("result raised straight after acceptance");

  a_dec_after_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> $past(state_q == S_EVAL && req_q == REQ_UPDATE && !hit_q))
    else $error("counter decrement without a miss fill");

  a_clear_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("left the clearing sweep into active work");

endmodule

`default_nettype wire

[sim/shrs_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the streaming-aware RRIP replacement core: mirrors the replacement
// state for every accepted transaction and checks each victim result in order.
// Depends on shrs_pkg for field widths and policy constants.
module shrs_checker #(
  parameter int unsigned NUM_SETS    = shrs_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS    = shrs_pkg::DEF_NUM_WAYS,
  parameter int unsigned SIG_ENTRIES = shrs_pkg::DEF_SIG_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           req_type_i,
  input  logic [10:0]                    set_index_i,
  input  logic [3:0]                     way_i,
  input  logic [shrs_pkg::BLK_W-1:0]     blk_addr_i,
  input  logic [shrs_pkg::PC_W-1:0]      pc_i,
  input  logic                           hit_i,
  input  logic                           victim_valid_i,
  input  logic [shrs_pkg::OUT_WAY_W-1:0] victim_way_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import shrs_pkg::*;

  localparam int unsigned LINES = NUM_SETS * NUM_WAYS;

  logic [RRPV_W-1:0]    rrpv_mem     [LINES];
  logic [SIG_W-1:0]     sig_mem      [LINES];
  logic [CTR_W-1:0]     reuse_mem    [SIG_ENTRIES];
  logic                 stream_mem   [NUM_SETS];
  logic [BLK_W-1:0]     last_blk_mem [NUM_SETS];
  logic [OUT_WAY_W-1:0] victims_due  [$];
  int                   fails;
  int                   checked;

  task automatic age_set_and_pick(input int unsigned base, output logic [OUT_WAY_W-1:0] pick);
    logic [RRPV_W-1:0] top;
    int unsigned       found;
    top = RRPV_NEAR;
    for (int unsigned w = 0; w < NUM_WAYS; w++) begin
      if (rrpv_mem[base+w] > top) top = rrpv_mem[base+w];
    end
    if (top < RRPV_MAX) begin
      for (int unsigned w = 0; w < NUM_WAYS; w++) begin
        rrpv_mem[base+w] = rrpv_mem[base+w] + (RRPV_MAX - top);
      end
    end
    found = 0;
    for (int unsigned w = NUM_WAYS; w > 0; w--) begin
      if (rrpv_mem[base+w-1] == RRPV_MAX) found = w - 1;
    end
    pick = OUT_WAY_W'(found);
  endtask

  task automatic apply_access(input logic [10:0] s, input logic [3:0] w_in,
                              input logic [BLK_W-1:0] blk, input logic [PC_W-1:0] p,
                              input logic is_hit);
    int unsigned      line_idx;
    int unsigned      gidx;
    int unsigned      eidx;
    logic [BLK_W-1:0] prev;
    logic [BLK_W-1:0] delta;
    logic [SIG_W-1:0] new_sig;
    logic [SIG_W-1:0] old_sig;
    prev     = last_blk_mem[s];
    delta    = blk - prev;
    new_sig  = SIG_W'(p ^ (p >> SIG_SHIFT)) & SIG_MASK;
    gidx     = int'((p ^ (p >> IDX_SHIFT) ^ (p >> SIG_SHIFT)) & 64'(SIG_ENTRIES - 1));
    line_idx = s * NUM_WAYS + w_in;
    if (prev != '0 && (delta == 1 || delta == '1)) begin
      stream_mem[s] = 1'b1;
    end else if (prev != '0 && delta != '0) begin
      stream_mem[s] = 1'b0;
    end
    last_blk_mem[s] = blk;
    if (is_hit) begin
      rrpv_mem[line_idx] = RRPV_NEAR;
      if (reuse_mem[gidx] < CTR_MAX) reuse_mem[gidx] = reuse_mem[gidx] + 1'b1;
    end else begin
      old_sig = sig_mem[line_idx];
      eidx = (32'(old_sig) ^ (32'(old_sig) << EIDX_SHIFT)) & (SIG_ENTRIES - 1);
      sig_mem[line_idx] = new_sig;
      if (stream_mem[s]) begin
        rrpv_mem[line_idx] = RRPV_MAX;
      end else begin
        rrpv_mem[line_idx] = (reuse_mem[gidx] >= CTR_THRESH) ? RRPV_NEAR : RRPV_MAX;
      end
      if (reuse_mem[eidx] > '0) reuse_mem[eidx] = reuse_mem[eidx] - 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_b
    logic [OUT_WAY_W-1:0] want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < LINES; i++) begin
        rrpv_mem[i] = RRPV_MAX;
        sig_mem[i]  = '0;
      end
      for (int unsigned i = 0; i < SIG_ENTRIES; i++) reuse_mem[i] = CTR_RESET;
      for (int unsigned i = 0; i < NUM_SETS; i++) begin
        stream_mem[i]   = 1'b0;
        last_blk_mem[i] = '0;
      end
      victims_due.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (victim_valid_i) begin
        if (victims_due.size() == 0) begin
          fails++;
          $display("%0t victim_way: expected none, actual %0d", $time, victim_way_i);
        end else begin
          want = victims_due.pop_front();
          checked++;
          if (victim_way_i !== want) begin
            fails++;
            $display("%0t victim_way: expected %0d, actual %0d", $time, want, victim_way_i);
          end
        end
      end
      if (start_i && !busy_i && set_index_i < NUM_SETS) begin
        if (req_type_i == REQ_VICTIM) begin
          age_set_and_pick(set_index_i * NUM_WAYS, want);
          victims_due.push_back(want);
        end else if (way_i < NUM_WAYS) begin
          apply_access(set_index_i, way_i, blk_addr_i, pc_i, hit_i);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= victims_due.size();
    checked_o    <= checked;
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Top of the replacement core testbench: clock, reset and request stimulus.
// Depends on shrs_pkg, the core itself and the shrs_checker scoreboard.
module tb_top;
  import shrs_pkg::*;

  localparam int CLK_HALF = 2;
  localparam int LIMIT    = 200000;
  localparam int PER_PHASE = 550;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  logic                 req_type   = REQ_VICTIM;
  logic [10:0]          set_index  = '0;
  logic [3:0]           way        = '0;
  logic [BLK_W-1:0]     blk_addr   = '0;
  logic [PC_W-1:0]      pc         = '0;
  logic                 hit        = 1'b0;
  logic                 victim_valid;
  logic [OUT_WAY_W-1:0] victim_way;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned cycle_count = 0;
  int          sent        = 0;
  int          idle_pct    = 0;

  logic [10:0]      hot_set  [6];
  logic [BLK_W-1:0] hot_last [6];
  logic [PC_W-1:0]  pc_pool  [8];

  always #(CLK_HALF) clk_i = ~clk_i;

  ship_rrip_streaming_replacement_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type),
    .set_index_i   (set_index),
    .way_i         (way),
    .blk_addr_i    (blk_addr),
    .pc_i          (pc),
    .hit_i         (hit),
    .victim_valid_o(victim_valid),
    .victim_way_o  (victim_way)
  );

  shrs_checker u_victim_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_type_i    (req_type),
    .set_index_i   (set_index),
    .way_i         (way),
    .blk_addr_i    (blk_addr),
    .pc_i          (pc),
    .hit_i         (hit),
    .victim_valid_i(victim_valid),
    .victim_way_i  (victim_way),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic issue(input logic rt, input logic [10:0] s, input logic [3:0] w,
                       input logic [BLK_W-1:0] b, input logic [PC_W-1:0] p, input logic h);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    req_type   <= rt;
    set_index  <= s;
    way        <= w;
    blk_addr   <= b;
    pc         <= p;
    hit        <= h;
    start      <= 1'b1;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  // Mostly accesses on one hot set with stride-one runs, then victim requests.
  task automatic run_episode();
    int unsigned      k;
    int unsigned      n;
    int unsigned      r;
    logic [BLK_W-1:0] b;
    logic [PC_W-1:0]  p;
    k = $urandom_range(5);
    n = $urandom_range(4, 24);
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) b = hot_last[k] + 1;
      else if (r < 60) b = hot_last[k] - 1;
      else if (r < 70) b = hot_last[k];
      else if (r < 75) b = '0;
      else b = $urandom;
      p = ($urandom_range(9) == 0) ? {$urandom, $urandom} : pc_pool[$urandom_range(7)];
      if ($urandom_range(9) == 0) begin
        issue(REQ_VICTIM, hot_set[k], 4'($urandom), b, p, 1'($urandom));
      end else begin
        hot_last[k] = b;
        issue(REQ_UPDATE, hot_set[k], 4'($urandom), b, p, $urandom_range(99) < 60);
      end
    end
    repeat ($urandom_range(1, 2)) begin
      issue(REQ_VICTIM, hot_set[k], 4'($urandom), $urandom, {$urandom, $urandom},
            1'($urandom));
    end
  endtask

  initial begin
    int          target;
    int          phase_pct [3];
    logic [63:0] p0;
    phase_pct = '{0, 88, 34};
    p0 = 64'h0000_0000_0000_0421;
    hot_set[0] = '0;
    hot_set[1] = '1;
    for (int i = 2; i < 6; i++) hot_set[i] = 11'($urandom);
    for (int i = 0; i < 6; i++) hot_last[i] = '0;
    for (int i = 0; i < 7; i++) pc_pool[i] = {32'($urandom), 25'd0, 7'($urandom_range(127))};
    pc_pool[7] = {$urandom, $urandom};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset state, insertion by counter, streaming up/down/hold/break
    issue(REQ_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0);
    issue(REQ_UPDATE, 11'd0, 4'd3, 32'h100, p0, 1'b0);
    issue(REQ_UPDATE, 11'd0, 4'd3, 32'h101, p0, 1'b1);
    issue(REQ_UPDATE, 11'd0, 4'd7, 32'h102, p0, 1'b1);
    issue(REQ_UPDATE, 11'd0, 4'd9, 32'h101, p0, 1'b0);
    issue(REQ_UPDATE, 11'd0, 4'd10, 32'h101, p0, 1'b0);
    issue(REQ_UPDATE, 11'd0, 4'd11, 32'h5000, p0, 1'b0);
    issue(REQ_VICTIM, 11'd0, 4'd15, '1, '1, 1'b1);
    // promote every way of the top set, forcing a full ageing pass
    for (int w = 15; w >= 0; w--) begin
      issue(REQ_UPDATE, 11'd2047, 4'(w), 32'hFFFF_FFFE + 32'(15 - w),
            (w % 2 == 0) ? '1 : '0, 1'b1);
    end
    issue(REQ_VICTIM, 11'd2047, 4'd0, '0, '0, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_pct[ph];
      target = sent + PER_PHASE;
      while (sent < target) begin
        if ($urandom_range(9) == 0) begin
          issue(1'($urandom), 11'($urandom), 4'($urandom), $urandom, {$urandom, $urandom},
                1'($urandom));
        end else begin
          run_episode();
        end
      end
    end
    start <= 1'b0;

    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (8) @(posedge clk_i);

    $display("Run summary: %0d requests over back-to-back, sparse and mixed-gap phases",
             sent);
    $display("Run summary: %0d victim ways compared with the predicted ways", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[ship_rrip_streaming_replacement_core.f]
design/shrs_pkg.sv
design/shrs_ram.sv
design/shrs_row_eval.sv
design/ship_rrip_streaming_replacement_core.sv
sim/shrs_checker.sv
sim/tb_top.sv
